>>> design/lrs_pkg.sv
// Package with the shared types and constants of the link reconnect supervisor.
`timescale 1ns / 1ps
package lrs_pkg;

	// Reset values of the configuration registers.
	localparam logic [31:0] ASSOC_WINDOW_RST = 32'd10000;
	localparam logic [31:0] BACKOFF_CAP_RST  = 32'd30000;
	localparam logic [26:0] BACKOFF_BASE_RST = 27'd1000;
	localparam logic [7:0]  FAIL_FALLBACK_RST = 8'd3;
	localparam logic [31:0] AP_PROBE_RST     = 32'd300000;

	// Failure count from which the capped retry delay applies.
	localparam logic [7:0] CAP_FAILS = 8'd6;
	localparam logic [7:0] FAIL_MAX  = 8'hFF;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_ASSOC_WINDOW  = 3'd0,
		REG_BACKOFF_CAP   = 3'd1,
		REG_BACKOFF_BASE  = 3'd2,
		REG_FAIL_FALLBACK = 3'd3,
		REG_AP_PROBE      = 3'd4
	} cfg_reg_t;

	// Current configuration, handed from the register file to the core.
	typedef struct packed {
		logic [31:0] assoc_window_ms;
		logic [31:0] backoff_cap_ms;
		logic [26:0] backoff_base_ms;
		logic [7:0]  failures_to_fallback;
		logic [31:0] ap_probe_ms;
	} cfg_t;

	// One input item (one tick).
	typedef struct packed {
		logic [31:0] now_ms;
		logic        reconnect_request;
		logic        link_connected;
		logic        creds_present;
		logic        stations_present;
		logic        ap_start_ok;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic       cmd_reload;
		logic       cmd_disconnect;
		logic       cmd_begin_assoc;
		logic       cmd_ap_up;
		logic       cmd_ap_down;
		logic       is_linked;
		logic       is_ap_active;
		logic       link_or_ap_up;
		logic       pulse_link_up;
		logic       pulse_ap_up;
		logic [7:0] fail_count_out;
	} out_item_t;

endpackage

>>> design/link_reconnect_supervisor_unit.sv
// Link reconnect supervisor: top level with input and result registers.
//
// Usage: each input item is one tick carrying the millisecond time and the
// radio and credential status. Every accepted item yields exactly one result
// item with the commands for that tick and the status after it.
// Both channels use valid/stall; an item moves at an edge where valid is high
// and stall is low. Configuration is written through cfg_wr_en, cfg_index and
// cfg_data while the block is idle; indexes past the last register are ignored.
// An accepted item waits in the input register until the result register is
// free or being taken; it is then processed and its result is loaded into the
// result register, where out_valid rises.
// Throughput: one item per cycle while the receiver does not stall; the state
// update is a single pass of compares, a shift and an add between the input
// register and the result register.
// When the receiver stalls, the result register holds; one further item is
// taken into the input register, after which in_stall rises until the result
// is taken. Reset clears the supervisor state and loads the default register
// values; no result is pending after reset.
`timescale 1ns / 1ps
module link_reconnect_supervisor_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  lrs_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output lrs_pkg::out_item_t out_data,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import lrs_pkg::*;

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result;
	out_item_t out_data_q;
	logic      out_valid_q;
	logic      advance;
	logic      step;

	lrs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The input stage moves on when the result register is free or being taken.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign step     = valid_s1 && advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	lrs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> design/lrs_cfg_regs.sv
// Configuration register file of the link reconnect supervisor.
`timescale 1ns / 1ps
module lrs_cfg_regs (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output lrs_pkg::cfg_t cfg
);
	import lrs_pkg::*;

	cfg_t cfg_q;

	// Register writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.assoc_window_ms      <= ASSOC_WINDOW_RST;
			cfg_q.backoff_cap_ms       <= BACKOFF_CAP_RST;
			cfg_q.backoff_base_ms      <= BACKOFF_BASE_RST;
			cfg_q.failures_to_fallback <= FAIL_FALLBACK_RST;
			cfg_q.ap_probe_ms          <= AP_PROBE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_ASSOC_WINDOW:  cfg_q.assoc_window_ms      <= cfg_data;
				REG_BACKOFF_CAP:   cfg_q.backoff_cap_ms       <= cfg_data;
				REG_BACKOFF_BASE:  cfg_q.backoff_base_ms      <= cfg_data[26:0];
				REG_FAIL_FALLBACK: cfg_q.failures_to_fallback <= cfg_data[7:0];
				REG_AP_PROBE:      cfg_q.ap_probe_ms          <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/lrs_core.sv
// Supervisor state and the single-pass update for one tick.
`timescale 1ns / 1ps
module lrs_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  lrs_pkg::in_item_t item,
	input  lrs_pkg::cfg_t     cfg,
	output lrs_pkg::out_item_t result
);
	import lrs_pkg::*;

	logic        linked_q, ap_on_q, associating_q, force_q;
	logic [7:0]  fail_count_q;
	logic [31:0] assoc_start_q, retry_time_q, probe_start_q;

	logic        linked_n, ap_on_n, associating_n, force_n;
	logic [7:0]  fail_count_n;
	logic [31:0] assoc_start_n, retry_time_n, probe_start_n;

	logic [7:0]  fail_inc;
	logic [2:0]  shift_amt;
	logic [31:0] delay;
	logic [31:0] assoc_elapsed, retry_diff, probe_elapsed;
	logic        window_done, retry_due, probe_due;
	logic        raise_req, raise_ok, begin_assoc;
	logic        o_reload, o_disc, o_ap_down, o_pulse_link;

	// Elapsed-time compares and the retry delay for the next failure.
	always_comb begin
		assoc_elapsed = item.now_ms - assoc_start_q;
		retry_diff    = item.now_ms - retry_time_q;
		probe_elapsed = item.now_ms - probe_start_q;
		window_done   = assoc_elapsed >= cfg.assoc_window_ms;
		retry_due     = ~retry_diff[31];
		probe_due     = probe_elapsed >= cfg.ap_probe_ms;
		fail_inc      = (fail_count_q == FAIL_MAX) ? FAIL_MAX : fail_count_q + 8'd1;
		shift_amt     = fail_inc[2:0] - 3'd1;
		if (fail_inc >= CAP_FAILS) begin
			delay = cfg.backoff_cap_ms;
		end else begin
			delay = {5'd0, cfg.backoff_base_ms} << shift_amt;
		end
	end

	// Next state and commands, in the priority order of the tick.
	always_comb begin
		linked_n      = linked_q;
		ap_on_n       = ap_on_q;
		associating_n = associating_q;
		force_n       = force_q;
		fail_count_n  = fail_count_q;
		assoc_start_n = assoc_start_q;
		retry_time_n  = retry_time_q;
		probe_start_n = probe_start_q;
		o_reload      = 1'b0;
		o_disc        = 1'b0;
		o_ap_down     = 1'b0;
		o_pulse_link  = 1'b0;
		raise_req     = 1'b0;
		begin_assoc   = 1'b0;

		priority if (item.reconnect_request) begin
			o_reload      = 1'b1;
			fail_count_n  = 8'd0;
			associating_n = 1'b0;
			retry_time_n  = item.now_ms;
			force_n       = 1'b1;
			if (linked_q) begin
				o_disc   = 1'b1;
				linked_n = 1'b0;
			end
		end else if (item.link_connected) begin
			if (!linked_q) begin
				linked_n      = 1'b1;
				associating_n = 1'b0;
				fail_count_n  = 8'd0;
				o_pulse_link  = 1'b1;
				if (ap_on_q) begin
					o_ap_down = 1'b1;
					ap_on_n   = 1'b0;
				end
			end
		end else begin
			// A lost link clears the count and makes the retry due now.
			if (linked_q) begin
				linked_n     = 1'b0;
				fail_count_n = 8'd0;
				retry_time_n = item.now_ms;
			end
			if (associating_q) begin
				if (window_done) begin
					associating_n = 1'b0;
					fail_count_n  = fail_inc;
					retry_time_n  = item.now_ms + delay;
					raise_req     = !ap_on_q && (fail_inc >= cfg.failures_to_fallback);
				end
			end else if (linked_q ? 1'b1 : retry_due) begin
				if (!item.creds_present) begin
					raise_req = !ap_on_q;
				end else if (ap_on_q && !force_q) begin
					if (!item.stations_present && probe_due) begin
						probe_start_n = item.now_ms;
						begin_assoc   = 1'b1;
					end
				end else begin
					if (ap_on_q) begin
						force_n = 1'b0;
					end
					begin_assoc = 1'b1;
				end
			end
		end

		// Access point bring-up only takes effect when it would succeed.
		raise_ok = raise_req && item.ap_start_ok;
		if (raise_ok) begin
			ap_on_n       = 1'b1;
			probe_start_n = item.now_ms;
		end
		if (begin_assoc) begin
			associating_n = 1'b1;
			assoc_start_n = item.now_ms;
		end
	end

	// Result fields show the state after this tick.
	always_comb begin
		result.cmd_reload      = o_reload;
		result.cmd_disconnect  = o_disc;
		result.cmd_begin_assoc = begin_assoc;
		result.cmd_ap_up       = raise_ok;
		result.cmd_ap_down     = o_ap_down;
		result.is_linked       = linked_n;
		result.is_ap_active    = ap_on_n;
		result.link_or_ap_up   = linked_n | ap_on_n;
		result.pulse_link_up   = o_pulse_link;
		result.pulse_ap_up     = raise_ok;
		result.fail_count_out  = fail_count_n;
	end

	// Control flags reset; the timestamps reset to zero as well.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			linked_q      <= 1'b0;
			ap_on_q       <= 1'b0;
			associating_q <= 1'b0;
			force_q       <= 1'b0;
			fail_count_q  <= 8'd0;
			assoc_start_q <= 32'd0;
			retry_time_q  <= 32'd0;
			probe_start_q <= 32'd0;
		end else if (step) begin
			linked_q      <= linked_n;
			ap_on_q       <= ap_on_n;
			associating_q <= associating_n;
			force_q       <= force_n;
			fail_count_q  <= fail_count_n;
			assoc_start_q <= assoc_start_n;
			retry_time_q  <= retry_time_n;
			probe_start_q <= probe_start_n;
		end
	end

	// State only moves when an item is processed.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(fail_count_q) && $stable(linked_q) && $stable(ap_on_q))
		else $error("supervisor state changed without an item");

	// A reconnect request always leaves the link down and a forced attempt pending.
	a_req: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.reconnect_request |=> !linked_q && force_q && fail_count_q == 8'd0)
		else $error("reconnect request not applied");

	// A connected report without a request leaves the link up and no attempt running.
	a_conn: assert property (@(posedge clk) disable iff (!arst_n)
		step && !item.reconnect_request && item.link_connected |=> linked_q && !associating_q)
		else $error("link connect not applied");

	// The access point is only raised while it is down, and never together with teardown or an association start.
	a_ap: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.cmd_ap_up |-> !ap_on_q && !result.cmd_ap_down && !result.cmd_begin_assoc)
		else $error("access point raised while already up or alongside another command");

endmodule

>>> tb/link_reconnect_supervisor_unit_test.sv
// Self-checking testbench for the link reconnect supervisor with a built-in predictor.
`timescale 1ns / 1ps

import lrs_pkg::*;

// Predicts each tick's result and checks the results the block returns.
class supervisor_scoreboard;
	// Register copy.
	logic [31:0] window_ms;
	logic [31:0] cap_ms;
	logic [26:0] base_ms;
	logic [7:0]  fallback_fails;
	logic [31:0] probe_ms;

	// Supervisor state.
	bit          linked;
	bit          ap_on;
	bit          associating;
	bit          force_attempt;
	logic [7:0]  fail_count;
	logic [31:0] assoc_start;
	logic [31:0] retry_time;
	logic [31:0] probe_start;

	out_item_t expected_q[$];

	int unsigned mismatches;
	int unsigned ticks;
	int unsigned checked;
	int unsigned assoc_starts;
	int unsigned ap_raises;
	int unsigned link_ups;
	int unsigned peak_fails;

	function new();
		window_ms = ASSOC_WINDOW_RST;
		cap_ms = BACKOFF_CAP_RST;
		base_ms = BACKOFF_BASE_RST;
		fallback_fails = FAIL_FALLBACK_RST;
		probe_ms = AP_PROBE_RST;
		linked = 0;
		ap_on = 0;
		associating = 0;
		force_attempt = 0;
		fail_count = '0;
		assoc_start = '0;
		retry_time = '0;
		probe_start = '0;
	endfunction

	// Mirrors a register write; indexes past the last register are ignored.
	function void write_reg(logic [2:0] idx, logic [31:0] val);
		case (cfg_reg_t'(idx))
			REG_ASSOC_WINDOW:  window_ms = val;
			REG_BACKOFF_CAP:   cap_ms = val;
			REG_BACKOFF_BASE:  base_ms = val[26:0];
			REG_FAIL_FALLBACK: fallback_fails = val[7:0];
			REG_AP_PROBE:      probe_ms = val;
			default: ;
		endcase
	endfunction

	// The access point comes up only when the radio says it can.
	function void raise_fallback(logic [31:0] now, logic ok, inout out_item_t r);
		if (ok) begin
			ap_on = 1;
			probe_start = now;
			r.cmd_ap_up = 1'b1;
			r.pulse_ap_up = 1'b1;
		end
	endfunction

	// Works out the result of one accepted tick and queues it.
	function void note_tick(in_item_t t);
		out_item_t   r;
		logic        start_assoc;
		logic [31:0] now;
		logic [31:0] elapsed;
		logic [31:0] delay;
		r = '0;
		start_assoc = 1'b0;
		now = t.now_ms;
		ticks++;

		if (t.reconnect_request) begin
			// Fresh credentials: restart with a forced attempt.
			r.cmd_reload = 1'b1;
			fail_count = '0;
			associating = 0;
			retry_time = now;
			force_attempt = 1;
			if (linked) begin
				r.cmd_disconnect = 1'b1;
				linked = 0;
			end
		end else if (t.link_connected) begin
			// The link has come up; the fallback access point is dropped.
			if (!linked) begin
				linked = 1;
				associating = 0;
				fail_count = '0;
				r.pulse_link_up = 1'b1;
				if (ap_on) begin
					r.cmd_ap_down = 1'b1;
					ap_on = 0;
				end
			end
		end else begin
			if (linked) begin
				linked = 0;
				fail_count = '0;
				retry_time = now;
			end
			if (associating) begin
				// Association window expiry schedules a retry with backoff.
				elapsed = now - assoc_start;
				if (elapsed >= window_ms) begin
					associating = 0;
					if (fail_count != FAIL_MAX)
						fail_count = fail_count + 8'd1;
					if (fail_count >= CAP_FAILS)
						delay = cap_ms;
					else
						delay = {5'd0, base_ms} << (fail_count - 8'd1);
					retry_time = now + delay;
					if (!ap_on && fail_count >= fallback_fails)
						raise_fallback(now, t.ap_start_ok, r);
				end
			end else begin
				elapsed = now - retry_time;
				if (!elapsed[31]) begin
					if (!t.creds_present) begin
						if (!ap_on)
							raise_fallback(now, t.ap_start_ok, r);
					end else if (ap_on && !force_attempt) begin
						// Unattended reprobe only when nobody is attached.
						elapsed = now - probe_start;
						if (!t.stations_present && elapsed >= probe_ms) begin
							probe_start = now;
							start_assoc = 1'b1;
						end
					end else begin
						if (ap_on)
							force_attempt = 0;
						start_assoc = 1'b1;
					end
				end
			end
		end

		if (start_assoc) begin
			r.cmd_begin_assoc = 1'b1;
			associating = 1;
			assoc_start = now;
		end

		r.is_linked = linked;
		r.is_ap_active = ap_on;
		r.link_or_ap_up = linked | ap_on;
		r.fail_count_out = fail_count;

		assoc_starts += 32'(r.cmd_begin_assoc);
		ap_raises += 32'(r.pulse_ap_up);
		link_ups += 32'(r.pulse_link_up);
		if (32'(fail_count) > peak_fails)
			peak_fails = 32'(fail_count);
		expected_q.push_back(r);
	endfunction

	function void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Mismatch on %s at result %0d: expected %0h, got %0h",
					name, checked, want, got);
		end
	endfunction

	// Compares one returned result with the oldest prediction.
	function void check_result(out_item_t got);
		out_item_t want;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Result %0h arrived with nothing predicted", got);
			return;
		end
		want = expected_q.pop_front();
		compare_field("cmd_reload", 8'(want.cmd_reload), 8'(got.cmd_reload));
		compare_field("cmd_disconnect", 8'(want.cmd_disconnect), 8'(got.cmd_disconnect));
		compare_field("cmd_begin_assoc", 8'(want.cmd_begin_assoc),
			8'(got.cmd_begin_assoc));
		compare_field("cmd_ap_up", 8'(want.cmd_ap_up), 8'(got.cmd_ap_up));
		compare_field("cmd_ap_down", 8'(want.cmd_ap_down), 8'(got.cmd_ap_down));
		compare_field("is_linked", 8'(want.is_linked), 8'(got.is_linked));
		compare_field("is_ap_active", 8'(want.is_ap_active), 8'(got.is_ap_active));
		compare_field("link_or_ap_up", 8'(want.link_or_ap_up), 8'(got.link_or_ap_up));
		compare_field("pulse_link_up", 8'(want.pulse_link_up), 8'(got.pulse_link_up));
		compare_field("pulse_ap_up", 8'(want.pulse_ap_up), 8'(got.pulse_ap_up));
		compare_field("fail_count_out", want.fail_count_out, got.fail_count_out);
		checked++;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module link_reconnect_supervisor_unit_test;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam logic [2:0] UNUSED_REG_INDEX = 3'd5;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_data;
	logic       cfg_wr_en = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// Idling switches for the sending and receiving sides.
	bit in_idle = 1'b1;
	bit out_idle = 1'b1;

	// Slowly changing radio and credential conditions for the random ticks.
	logic [31:0] tick_time = '0;
	bit          radio_link = 1'b0;
	bit          creds_level = 1'b1;
	bit          station_level = 1'b0;

	int unsigned settings = 1;
	int unsigned idle_cycles = 0;

	supervisor_scoreboard sb = new();

	link_reconnect_supervisor_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 50 MHz clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Receiver stalls at random while idling is enabled.
	always @(posedge clk) begin
		out_stall <= out_idle && ($urandom_range(0, 99) < 10);
	end

	// Track register writes, accepted items and returned results.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				sb.write_reg(cfg_index, cfg_data);
			if (in_valid && !in_stall)
				sb.note_tick(in_data);
			if (out_valid && !out_stall)
				sb.check_result(out_data);
		end
	end

	// Ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic in_item_t make_tick(logic [31:0] now, bit req, bit conn,
		bit creds, bit stations, bit ok);
		in_item_t t;
		t.now_ms = now;
		t.reconnect_request = req;
		t.link_connected = conn;
		t.creds_present = creds;
		t.stations_present = stations;
		t.ap_start_ok = ok;
		return t;
	endfunction

	// Offers one item and returns at the edge where it is taken.
	task automatic send_tick(in_item_t t);
		if (in_idle && $urandom_range(0, 99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (in_stall);
	endtask

	// Stops sending and waits until every predicted result has come back.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (2) @(posedge clk);
	endtask

	// Writes all registers, then one write to an unused index.
	task automatic configure(logic [31:0] window, logic [31:0] cap, logic [26:0] base,
		logic [7:0] fails, logic [31:0] probe);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_ASSOC_WINDOW;
		cfg_data <= window;
		@(posedge clk);
		cfg_index <= REG_BACKOFF_CAP;
		cfg_data <= cap;
		@(posedge clk);
		cfg_index <= REG_BACKOFF_BASE;
		cfg_data <= {5'd0, base};
		@(posedge clk);
		cfg_index <= REG_FAIL_FALLBACK;
		cfg_data <= {24'd0, fails};
		@(posedge clk);
		cfg_index <= REG_AP_PROBE;
		cfg_data <= probe;
		@(posedge clk);
		cfg_index <= UNUSED_REG_INDEX;
		cfg_data <= $urandom;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		settings++;
	endtask

	// Random ticks; time moves in steps scaled to the current register setting.
	// The saturation mode keeps the link down so failures pile up.
	task automatic random_ticks(int unsigned count, int unsigned scale, int unsigned big,
		bit saturate);
		int unsigned pick;
		logic [31:0] step;
		bit          req;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (saturate)
				step = (pick < 5) ? 32'd0 : $urandom_range(1, 3);
			else if (pick < 8)
				step = 32'd0;
			else if (pick < 16)
				step = 32'd1;
			else if (pick < 70)
				step = $urandom_range(0, scale);
			else if (pick < 94)
				step = $urandom_range(0, big);
			else
				step = $urandom;
			tick_time = tick_time + step;

			if (saturate) begin
				req = 1'b0;
				radio_link = 1'b0;
				creds_level = 1'b1;
			end else begin
				req = ($urandom_range(0, 99) < 4);
				if (radio_link)
					radio_link = ($urandom_range(0, 99) >= 12);
				else
					radio_link = ($urandom_range(0, 99) < 8);
				if (creds_level)
					creds_level = ($urandom_range(0, 99) >= 5);
				else
					creds_level = ($urandom_range(0, 99) < 25);
			end
			if ($urandom_range(0, 99) < 10)
				station_level = !station_level;

			send_tick(make_tick(tick_time, req, radio_link, creds_level, station_level,
				$urandom_range(0, 99) < 80));
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk through the reset settings: backoff, failed and good
		// access point bring-up, reprobe, link up and loss, reconnect, wrap.
		send_tick(make_tick(32'd0, 0, 0, 1, 0, 1));
		send_tick(make_tick(32'd5000, 0, 0, 1, 0, 1));
		send_tick(make_tick(32'd10000, 0, 0, 1, 0, 1));
		send_tick(make_tick(32'd10500, 0, 0, 1, 0, 1));
		send_tick(make_tick(32'd11000, 0, 0, 1, 0, 1));
		send_tick(make_tick(32'd21000, 0, 0, 1, 0, 1));
		send_tick(make_tick(32'd23000, 0, 0, 1, 0, 1));
		send_tick(make_tick(32'd33000, 0, 0, 1, 0, 0));
		send_tick(make_tick(32'd37000, 0, 0, 0, 0, 0));
		send_tick(make_tick(32'd37001, 0, 0, 0, 0, 1));
		send_tick(make_tick(32'd37002, 0, 0, 1, 1, 1));
		send_tick(make_tick(32'd337002, 0, 0, 1, 1, 1));
		send_tick(make_tick(32'd337002, 0, 0, 1, 0, 1));
		send_tick(make_tick(32'd337010, 0, 1, 1, 0, 1));
		send_tick(make_tick(32'd337011, 0, 1, 1, 0, 1));
		send_tick(make_tick(32'd337012, 1, 1, 1, 0, 1));
		send_tick(make_tick(32'd337013, 1, 0, 1, 0, 1));
		send_tick(make_tick(32'd337014, 0, 0, 1, 0, 1));
		send_tick(make_tick(32'd347014, 0, 0, 1, 0, 1));
		send_tick(make_tick(32'd348014, 0, 0, 0, 0, 1));
		send_tick(make_tick(32'd348015, 0, 0, 1, 0, 1));
		send_tick(make_tick(32'hFFFF_FFFF, 0, 0, 1, 1, 1));
		send_tick(make_tick(32'd0, 0, 1, 1, 1, 1));
		send_tick(make_tick(32'd5, 0, 0, 1, 0, 1));
		tick_time = 32'd10;

		// Reset settings, long time steps.
		random_ticks(220, 12000, 400000, 0);

		// Short windows and delays, access point on the first failure.
		configure($urandom_range(1, 20), $urandom_range(1, 100),
			27'($urandom_range(1, 8)), 8'd1, $urandom_range(1, 50));
		random_ticks(300, 30, 200, 0);

		// Every register at its top value.
		configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 27'h7FF_FFFF, 8'd255, 32'hFFFF_FFFF);
		random_ticks(120, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);

		// Mid-range settings with both sides running flat out.
		in_idle = 1'b0;
		out_idle = 1'b0;
		configure($urandom_range(1, 2000), $urandom_range(1, 5000),
			27'($urandom_range(1, 500)), 8'($urandom_range(1, 8)),
			$urandom_range(1, 20000));
		random_ticks(200, 2500, 25000, 0);
		in_idle = 1'b1;
		out_idle = 1'b1;

		// Link kept down long enough for the failure count to saturate.
		configure(32'd1, 32'd2, 27'd1, 8'd255, 32'd3);
		random_ticks(800, 3, 3, 1);

		// Every register at one, its lowest nonzero value.
		configure(32'd1, 32'd1, 27'd1, 8'd1, 32'd1);
		random_ticks(100, 4, 16, 0);

		drain();
		repeat (4) @(posedge clk);

		$display("Covered %0d ticks under %0d register settings; %0d results checked.",
			sb.ticks, settings, sb.checked);
		$display("Saw %0d association starts, %0d access point raises, %0d link-ups, %s %0d.",
			sb.assoc_starts, sb.ap_raises, sb.link_ups, "peak failure count",
			sb.peak_fails);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d results still outstanding",
				sb.mismatches, sb.pending());
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
